[rtl/rcf_pkg.sv]
`default_nettype none

package rcf_pkg;

    // Operation codes of an input beat.
    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_CRC_PRESET     = 2'd1;
    localparam logic [1:0] REG_CRC_POLY       = 2'd2;
    localparam logic [1:0] REG_HEADER_LENGTH  = 2'd3;

    // Register reset values.
    localparam logic [7:0]  RST_DEVICE_ADDRESS = 8'h00;
    localparam logic [15:0] RST_CRC_PRESET     = 16'hFFFF;
    localparam logic [15:0] RST_CRC_POLY       = 16'h8408;
    localparam logic [7:0]  RST_HEADER_LENGTH  = 8'd4;

    // Step numbers of the emitter.
    localparam logic [2:0] STEP_FIRST   = 3'd0;
    localparam logic [2:0] STEP_SECOND  = 3'd1;
    localparam logic [2:0] STEP_THIRD   = 3'd2;
    localparam logic [2:0] STEP_CRC_LO  = 3'd3;
    localparam logic [2:0] STEP_CRC_HI  = 3'd4;

    typedef enum logic {
        KIND_BEGIN = 1'b0,
        KIND_DATA  = 1'b1
    } t_kind;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [7:0]  device_address;
        logic [15:0] crc_preset;
        logic [15:0] crc_poly;
        logic [7:0]  header_length;
    } t_cfg;

    // One classified job handed from the front to the emitter.
    typedef struct packed {
        t_kind       kind;
        logic        crc_after;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [15:0] preset;
    } t_entry;

    // Reflected CRC update over one byte, one bit per step.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/rcf_cmd_if.sv]
`default_nettype none

interface rcf_cmd_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;

    modport source (output valid, operation, command, payload_length, payload_byte,
                    input ready);
    modport sink (input valid, operation, command, payload_length, payload_byte,
                  output ready);
endinterface

`default_nettype wire

[rtl/rcf_frame_if.sv]
`default_nettype none

interface rcf_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink (input valid, frame_byte, frame_last, output ready);
endinterface

`default_nettype wire

[rtl/rcf_front.sv]
`default_nettype none

module rcf_front
    import rcf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_valid,
    input  wire logic   i_operation,
    input  wire logic [7:0] i_command,
    input  wire logic [7:0] i_payload_length,
    input  wire logic [7:0] i_payload_byte,
    output logic        o_ready,
    input  wire logic   i_push_ready,
    output logic        o_push,
    output t_entry      o_entry
);

    logic       r_open;
    logic [7:0] r_remaining;
    logic       n_open;
    logic [7:0] n_remaining;
    logic       accept;

    // Every beat is taken while the queue has room, ignored ones too.
    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;

    // Classify the beat and build the job for the emitter.
    always_comb begin
        n_open      = r_open;
        n_remaining = r_remaining;
        o_push      = 1'b0;
        o_entry     = '0;
        if (accept) begin
            if (i_operation == OP_BEGIN) begin
                o_push            = 1'b1;
                o_entry.kind      = KIND_BEGIN;
                o_entry.crc_after = (i_payload_length == 8'd0);
                o_entry.byte0     = i_cfg.header_length + i_payload_length;
                o_entry.byte1     = i_cfg.device_address;
                o_entry.byte2     = i_command;
                o_entry.preset    = i_cfg.crc_preset;
                n_open            = (i_payload_length != 8'd0);
                n_remaining       = i_payload_length;
            end else if (r_open) begin
                o_push            = 1'b1;
                o_entry.kind      = KIND_DATA;
                o_entry.crc_after = (r_remaining == 8'd1);
                o_entry.byte0     = i_payload_byte;
                n_remaining       = r_remaining - 8'd1;
                n_open            = (r_remaining != 8'd1);
            end
        end
    end

    // Frame tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 8'd0;
        end else begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

`default_nettype wire

[rtl/rcf_queue.sv]
`default_nettype none

module rcf_queue
    import rcf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_push_ready,
    input  wire logic   i_pop,
    output logic        o_head_valid,
    output t_entry      o_head
);

    t_entry     r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_push_ready = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_slot[r_rptr];

    // Occupancy follows pushes and pops.
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

[rtl/rcf_back.sv]
`default_nettype none

module rcf_back
    import rcf_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic [15:0] i_poly,
    input  wire logic   i_head_valid,
    input  wire t_entry i_head,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_last
);

    logic [2:0]  r_step;
    logic [15:0] r_crc;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;

    logic [2:0]  n_step;
    logic [15:0] n_crc;
    logic [7:0]  n_byte;
    logic        n_last;
    logic        load;
    logic [2:0]  last_step;
    logic        is_crc;
    logic        is_crc_hi;
    logic [15:0] crc_base;

    // The output register takes a new beat when empty or being drained.
    assign load = i_head_valid && (!r_valid || i_ready);

    // Pick the byte for the current step and update the running CRC.
    always_comb begin
        if (i_head.kind == KIND_BEGIN) begin
            last_step = i_head.crc_after ? STEP_CRC_HI : STEP_THIRD;
            is_crc    = (r_step >= STEP_CRC_LO);
            is_crc_hi = (r_step == STEP_CRC_HI);
        end else begin
            last_step = i_head.crc_after ? STEP_THIRD : STEP_FIRST;
            is_crc    = (r_step >= STEP_SECOND);
            is_crc_hi = (r_step == STEP_THIRD);
        end

        unique case (r_step)
            STEP_SECOND: n_byte = i_head.byte1;
            STEP_THIRD:  n_byte = i_head.byte2;
            default:     n_byte = i_head.byte0;
        endcase
        if (is_crc) begin
            n_byte = is_crc_hi ? r_crc[15:8] : r_crc[7:0];
        end
        n_last = is_crc && is_crc_hi;

        if (i_head.kind == KIND_BEGIN && r_step == STEP_FIRST) begin
            crc_base = i_head.preset;
        end else begin
            crc_base = r_crc;
        end
        n_crc = is_crc ? r_crc : crc_feed(crc_base, n_byte, i_poly);

        o_pop  = load && (r_step == last_step);
        n_step = o_pop ? STEP_FIRST : r_step + 3'd1;
    end

    // Step counter and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= STEP_FIRST;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step  <= n_step;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload and CRC register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_last <= n_last;
            r_crc  <= n_crc;
        end
    end

    assign o_valid      = r_valid;
    assign o_frame_byte = r_byte;
    assign o_frame_last = r_last;

endmodule

`default_nettype wire

[rtl/reader_command_framer_crc16_unit.sv]
`default_nettype none

// Reader command framer with a reflected CRC-16.
// i_cmd carries input beats: a begin beat (operation 0) with the command and
// the payload length, or a payload beat (operation 1) with one payload byte.
// o_frame carries the frame one byte per beat: length, device address,
// command, the payload bytes, then the CRC low byte and the CRC high byte,
// which is marked by frame_last. A payload beat with no frame open is taken
// and dropped. The APB port holds device address, CRC preset, CRC polynomial
// and header length at byte addresses 0, 4, 8 and 12.
// A beat passes the queue and then the byte-wide output register before
// its first byte is valid on o_frame. Payload bytes flow at one per cycle
// while o_frame.ready is high; a begin beat emits three header bytes (and
// the CRC if the payload is empty), the last payload beat its byte and CRC.
// A two-entry queue separates the classifying front from the emitter, so a
// stalled receiver fills the queue and then holds i_cmd.ready low; nothing
// is lost. Reset clears the queue, the open-frame state and the output beat
// and restores the register defaults.
module reader_command_framer_crc16_unit
    import rcf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rcf_cmd_if.sink          i_cmd,
    rcf_frame_if.source      o_frame,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg   r_cfg;
    logic   push;
    logic   push_ready;
    logic   pop;
    logic   head_valid;
    t_entry push_entry;
    t_entry head;
    logic [1:0] reg_index;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= RST_DEVICE_ADDRESS;
            r_cfg.crc_preset     <= RST_CRC_PRESET;
            r_cfg.crc_poly       <= RST_CRC_POLY;
            r_cfg.header_length  <= RST_HEADER_LENGTH;
        end else if (psel && penable && pwrite) begin
            unique case (reg_index)
                REG_DEVICE_ADDRESS: r_cfg.device_address <= pwdata[7:0];
                REG_CRC_PRESET:     r_cfg.crc_preset     <= pwdata[15:0];
                REG_CRC_POLY:       r_cfg.crc_poly       <= pwdata[15:0];
                REG_HEADER_LENGTH:  r_cfg.header_length  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (reg_index)
            REG_DEVICE_ADDRESS: prdata = {24'h0, r_cfg.device_address};
            REG_CRC_PRESET:     prdata = {16'h0, r_cfg.crc_preset};
            REG_CRC_POLY:       prdata = {16'h0, r_cfg.crc_poly};
            REG_HEADER_LENGTH:  prdata = {24'h0, r_cfg.header_length};
            default:            prdata = 32'h0;
        endcase
    end

    rcf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (i_cmd.valid),
        .i_operation      (i_cmd.operation),
        .i_command        (i_cmd.command),
        .i_payload_length (i_cmd.payload_length),
        .i_payload_byte   (i_cmd.payload_byte),
        .o_ready          (i_cmd.ready),
        .i_push_ready     (push_ready),
        .o_push           (push),
        .o_entry          (push_entry)
    );

    rcf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (push_entry),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    rcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poly       (r_cfg.crc_poly),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_frame.valid),
        .i_ready      (o_frame.ready),
        .o_frame_byte (o_frame.frame_byte),
        .o_frame_last (o_frame.frame_last)
    );

endmodule

`default_nettype wire
